/* hw/rtl/stdsp_pkg.sv */
// Package for the step-triggered decaying sine ping unit.
// Holds the item types, register indexes, fixed constants, controller/datapath
// command types and the quarter-wave sine function. Depends on nothing.
`default_nettype none

package stdsp_pkg;

   typedef struct packed {
      logic        sensor_valid;
      logic [15:0] sensor_value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] audio_sample;
      logic               foot_is_down;
   } rsp_type;

   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRESHOLD_HIGH = 3'd0,
      CSR_THRESHOLD_LOW  = 3'd1,
      CSR_PHASE_STEP     = 3'd2,
      CSR_DECAY_FACTOR   = 3'd3,
      CSR_STRIKE_LEVEL   = 3'd4,
      CSR_SILENCE_FLOOR  = 3'd5
   } csr_index_type;

   localparam logic [15:0] RST_THRESHOLD_HIGH = 16'd54198;
   localparam logic [15:0] RST_THRESHOLD_LOW  = 16'd54067;
   localparam logic [31:0] RST_PHASE_STEP     = 32'd42852281;
   localparam logic [15:0] RST_DECAY_FACTOR   = 16'd65503;
   localparam logic [15:0] RST_STRIKE_LEVEL   = 16'd39322;
   localparam logic [15:0] RST_SILENCE_FLOOR  = 16'd66;

   // Output gain of 0.8 in unsigned Q0.16.
   localparam logic [15:0] GAIN_Q16    = 16'd52429;
   // pi/2 in Q30.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Operand pairs of the shared multiplier.
   typedef enum logic [1:0] {
      MUL_ENV_BY_SINE,
      MUL_GAIN,
      MUL_DECAY
   } mul_sel_type;

   typedef struct packed {
      logic        accept;    // run the step detector on the accepted item
      logic        lookup;    // read the sine table, decide if the frame sounds
      logic        mul_en;    // load the product register
      mul_sel_type mul_sel;
      logic        mag_load;  // capture the scaled sine magnitude
      logic        finish;    // load the result register, update state
   } cmd_type;

   typedef struct packed {
      logic out_free;         // result register can take a new item
   } status_type;

   // sin(pi/2 * r / 2^qbits) in Q1.15 magnitude, Taylor series to the 11th
   // order in Q30. Only used to fill the constant table at elaboration.
   function automatic logic [14:0] quarter_sine(input int unsigned r,
                                                input int unsigned qbits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        v;
      logic signed [63:0] sum;
      x    = (HALF_PI_Q30 * 64'(r)) >> qbits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      if (sum < 0) begin
         sum = 64'sd0;
      end
      v = (($unsigned(sum) * 64'd32767) + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[14:0];
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/step_triggered_decaying_sine_ping_unit.sv */
// Step-triggered decaying sine ping unit: one audio sample per frame item,
// with a hysteresis step detector that strikes a decaying sine tone.
// Top level; instantiates stdsp_ctrl and stdsp_datapath, uses stdsp_pkg.
//
// Usage. Each item on the req_ channel is one audio frame, optionally carrying
// a pressure sample. For every accepted item exactly one item appears on the
// rsp_ channel: the audio sample and the detector state after that frame.
// The csr_ channel writes the six configuration registers by index; it is
// always ready, and indexes past the last register are ignored. Write it only
// while no frame is in flight.
//
// Timing. A frame is accepted while the unit is idle. It then passes through the
// table lookup, the three multiplies and the result load, and the unit is idle
// again, ready for the next frame, once its result is loaded. The pace is
// set by the single 32x16 multiplier, which is used three times per frame
// (envelope, gain and decay), plus the registered sine table read.
//
// Reset is synchronous: it restores the register defaults, lifts the foot,
// silences the envelope and clears the phase. If the receiver stalls, the
// result waits in the output register; the next frame is still accepted and
// worked on, and it holds just before its result load until the register frees.
`default_nettype none

module step_triggered_decaying_sine_ping_unit #(
   parameter int unsigned SINE_TABLE_BITS = 10,
   parameter int unsigned PHASE_BITS      = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire stdsp_pkg::req_type                   req_item,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output stdsp_pkg::rsp_type                        rsp_item,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [stdsp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [stdsp_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   stdsp_pkg::cmd_type    cmd;
   stdsp_pkg::status_type status;

   // Register writes are never stalled.
   assign csr_ready = 1'b1;

   // The controller walks each frame through its steps.
   stdsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the configuration, state and result registers, the table and the multiplier.
   stdsp_datapath #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .PHASE_BITS      (PHASE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // Only one frame is in flight: acceptance closes the input until the end.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while a frame is in flight");

   // A result is never loaded over one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten");

   // The 0.8 gain bounds the sample magnitude.
   a_sample_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.audio_sample <= 16'sd26213 &&
                     rsp_item.audio_sample >= -16'sd26213))
      else $error("audio sample out of range");

endmodule

`default_nettype wire

/* hw/rtl/stdsp_ctrl.sv */
// Controller of the step-triggered decaying sine ping unit.
// Sequences one item through lookup, three multiplies and result load.
// Depends on stdsp_pkg.
`default_nettype none

module stdsp_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire stdsp_pkg::status_type status,
   output stdsp_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_MUL_ENV,
      ST_MUL_GAIN,
      ST_MUL_DECAY,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.mul_sel  = stdsp_pkg::MUL_ENV_BY_SINE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_MUL_ENV;
         end
         ST_MUL_ENV: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = stdsp_pkg::MUL_ENV_BY_SINE;
            state_in    = ST_MUL_GAIN;
         end
         ST_MUL_GAIN: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = stdsp_pkg::MUL_GAIN;
            state_in    = ST_MUL_DECAY;
         end
         ST_MUL_DECAY: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = stdsp_pkg::MUL_DECAY;
            cmd.mag_load = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            // Wait here while the previous result still sits unread.
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/stdsp_datapath.sv */
// Datapath of the step-triggered decaying sine ping unit: registers, step
// detector, sine table, shared multiplier and result register.
// Depends on stdsp_pkg.
`default_nettype none

module stdsp_datapath #(
   parameter int unsigned SINE_TABLE_BITS = 10,
   parameter int unsigned PHASE_BITS      = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_valid,
   input  wire logic [stdsp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [stdsp_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  wire stdsp_pkg::req_type                     req_item,
   input  wire stdsp_pkg::cmd_type                     cmd,
   output stdsp_pkg::status_type                       status,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output stdsp_pkg::rsp_type                          rsp_item
);

   localparam int unsigned QUARTER_BITS = SINE_TABLE_BITS - 2;
   localparam int unsigned QUARTER      = 1 << QUARTER_BITS;
   localparam int unsigned ADDR_BITS    = QUARTER_BITS + 1;

   // Configuration registers.
   logic [15:0]           thr_high_ff;
   logic [15:0]           thr_low_ff;
   logic [31:0]           phase_step_ff;
   logic [15:0]           decay_ff;
   logic [15:0]           strike_ff;
   logic [15:0]           floor_ff;

   // Block state.
   logic                  foot_ff;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [15:0]           env_ff;

   // Working registers of one item.
   logic [14:0]           sine_ff;
   logic                  sign_ff;
   logic                  sound_ff;
   logic [47:0]           prod_ff;
   logic [15:0]           mag_ff;

   logic                  rsp_valid_ff;
   stdsp_pkg::rsp_type    rsp_item_ff;

   // Quarter-wave sine table, entries 0 through QUARTER inclusive.
   logic [14:0]           sine_rom [QUARTER+1];

   for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
      assign sine_rom[k] = stdsp_pkg::quarter_sine(k, QUARTER_BITS);
   end

   logic [SINE_TABLE_BITS-1:0] tab_idx;
   logic [ADDR_BITS-1:0]       rom_r;
   logic [ADDR_BITS-1:0]       rom_addr;

   // Odd quadrants read the table backwards; the upper half negates.
   always_comb begin
      tab_idx  = phase_ff[PHASE_BITS-1 -: SINE_TABLE_BITS];
      rom_r    = {1'b0, tab_idx[QUARTER_BITS-1:0]};
      rom_addr = tab_idx[QUARTER_BITS] ? (ADDR_BITS'(QUARTER) - rom_r) : rom_r;
   end

   logic [31:0] mul_a;
   logic [15:0] mul_b;
   logic [47:0] mul_p;

   always_comb begin
      case (cmd.mul_sel)
         stdsp_pkg::MUL_ENV_BY_SINE: begin
            mul_a = {17'd0, sine_ff};
            mul_b = env_ff;
         end
         stdsp_pkg::MUL_GAIN: begin
            mul_a = prod_ff[31:0];
            mul_b = stdsp_pkg::GAIN_Q16;
         end
         stdsp_pkg::MUL_DECAY: begin
            mul_a = {16'd0, env_ff};
            mul_b = decay_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = {16'd0, mul_a} * {32'd0, mul_b};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_high_ff   <= stdsp_pkg::RST_THRESHOLD_HIGH;
         thr_low_ff    <= stdsp_pkg::RST_THRESHOLD_LOW;
         phase_step_ff <= stdsp_pkg::RST_PHASE_STEP;
         decay_ff      <= stdsp_pkg::RST_DECAY_FACTOR;
         strike_ff     <= stdsp_pkg::RST_STRIKE_LEVEL;
         floor_ff      <= stdsp_pkg::RST_SILENCE_FLOOR;
      end else if (csr_valid) begin
         unique case (csr_index)
            stdsp_pkg::CSR_THRESHOLD_HIGH: thr_high_ff   <= csr_data[15:0];
            stdsp_pkg::CSR_THRESHOLD_LOW:  thr_low_ff    <= csr_data[15:0];
            stdsp_pkg::CSR_PHASE_STEP:     phase_step_ff <= csr_data;
            stdsp_pkg::CSR_DECAY_FACTOR:   decay_ff      <= csr_data[15:0];
            stdsp_pkg::CSR_STRIKE_LEVEL:   strike_ff     <= csr_data[15:0];
            stdsp_pkg::CSR_SILENCE_FLOOR:  floor_ff      <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         foot_ff  <= 1'b0;
         phase_ff <= '0;
         env_ff   <= '0;
      end else if (cmd.accept) begin
         if (req_item.sensor_valid) begin
            if (!foot_ff) begin
               if (req_item.sensor_value > thr_high_ff) begin
                  foot_ff <= 1'b1;
                  env_ff  <= strike_ff;
               end
            end else if (req_item.sensor_value < thr_low_ff) begin
               foot_ff <= 1'b0;
            end
         end
      end else if (cmd.finish) begin
         if (sound_ff) begin
            phase_ff <= phase_ff + phase_step_ff[PHASE_BITS-1:0];
            env_ff   <= prod_ff[31:16];
         end else begin
            env_ff   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         sine_ff  <= sine_rom[rom_addr];
         sign_ff  <= tab_idx[SINE_TABLE_BITS-1];
         sound_ff <= env_ff > floor_ff;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
      end
      if (cmd.mag_load) begin
         mag_ff <= prod_ff[47:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_item_ff.foot_is_down <= foot_ff;
         if (!sound_ff) begin
            rsp_item_ff.audio_sample <= '0;
         end else if (sign_ff) begin
            rsp_item_ff.audio_sample <= $signed(16'd0 - mag_ff);
         end else begin
            rsp_item_ff.audio_sample <= $signed(mag_ff);
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item        = rsp_item_ff;

endmodule

`default_nettype wire
